### src/satlb_pkg.sv
// Shared types, codes and default sizes for the set-associative TLB.
package satlb_pkg;

   // Default geometry of the buffer.
   localparam int DEFAULT_PAGE_OFFSET_BITS = 12;
   localparam int DEFAULT_SET_COUNT = 16;
   localparam int DEFAULT_WAY_COUNT = 4;

   // Fixed field widths.
   localparam int ADDR_W = 64;
   localparam int TAG_W = 48;
   localparam int FRAME_W = 52;
   localparam int RANK_OUT_W = 3;

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_TRANSLATE = 2'd0,
      OP_FILL      = 2'd1,
      OP_PEEK      = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   // Response status codes.
   typedef enum logic [2:0] {
      RSP_HIT       = 3'd0,
      RSP_MISS      = 3'd1,
      RSP_FAULT     = 3'd2,
      RSP_INSTALLED = 3'd3,
      RSP_PEEK_DONE = 3'd4,
      RSP_CLEARED   = 3'd5
   } rsp_status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_UPDATE
   } state_type;

   // One request item.
   typedef struct packed {
      logic [1:0]        operation;
      logic [ADDR_W-1:0] virtual_address;
      logic [ADDR_W-1:0] walk_frame_address;
      logic              walk_fault;
   } req_type;

   // One response item.
   typedef struct packed {
      logic [2:0]            status;
      logic [ADDR_W-1:0]     physical_address;
      logic [RANK_OUT_W-1:0] recency_rank;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic mem_read;
      logic commit;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic out_free;
   } dp_sts_type;

endpackage

### src/set_associative_tlb_lru_core.sv
// Top level of the set-associative TLB with true-LRU replacement.
//
//   Channel   Ports                                  Direction  Moves
//   request   req_valid, req_stall, req_payload      in         one operation
//   response  rsp_valid, rsp_stall, rsp_payload      out        one result
//
// An item passes through accept, set/tag split, row read and update; the split is a bit
// split when SET_COUNT is a power of two, and otherwise divides one byte of the page
// number per cycle by reciprocal multiplication. One item is in flight at a time.
// Reset is synchronous and empties the buffer at once through per-set row flags; no
// clearing pass is needed, and the clear operation works the same way.
// A stalled response waits in the output register; the next request is still taken,
// and its update waits only if the previous result has not yet been transferred.
module set_associative_tlb_lru_core #(
   parameter int PAGE_OFFSET_BITS = satlb_pkg::DEFAULT_PAGE_OFFSET_BITS,
   parameter int SET_COUNT = satlb_pkg::DEFAULT_SET_COUNT,
   parameter int WAY_COUNT = satlb_pkg::DEFAULT_WAY_COUNT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  satlb_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output satlb_pkg::rsp_type rsp_payload
);

   satlb_pkg::ctl_cmd_type cmd;
   satlb_pkg::dp_sts_type  sts;

   // Sequencer.
   satlb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   // Lookup, memories and result register.
   satlb_dp #(
      .PAGE_OFFSET_BITS(PAGE_OFFSET_BITS),
      .SET_COUNT       (SET_COUNT),
      .WAY_COUNT       (WAY_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

### src/satlb_div.sv
// Splits the virtual page number into set index (remainder) and tag (quotient).
module satlb_div #(
   parameter int DIVIDEND_W = 52,
   parameter int SET_COUNT = satlb_pkg::DEFAULT_SET_COUNT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DIVIDEND_W-1:0]         dividend,
   output logic [DIVIDEND_W-1:0]         quotient,
   output logic [$clog2(SET_COUNT)-1:0]  remainder,
   output logic                          done
);

   localparam int SET_W = $clog2(SET_COUNT);
   localparam bit IS_POW2 = ((1 << SET_W) == SET_COUNT);

   generate
      if (IS_POW2) begin : g_split
         logic [DIVIDEND_W-1:0] quo_ff;
         logic [SET_W-1:0]      rem_ff;
         logic                  done_ff;

         // A power-of-two set count is a plain bit split.
         always_ff @(posedge clock) begin
            if (start) begin
               quo_ff <= dividend >> SET_W;
               rem_ff <= dividend[SET_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         assign quotient = quo_ff;
         assign remainder = rem_ff;
         assign done = done_ff;
      end else begin : g_recip
         localparam int DIGITS = (DIVIDEND_W + 7) / 8;
         localparam int PAD_W = DIGITS * 8;
         localparam int CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
         localparam int VAL_W = SET_W + 8;
         localparam int RECIP_SHIFT = 24;
         localparam int RECIP_W = RECIP_SHIFT + 1;
         localparam int PROD_W = VAL_W + RECIP_W;
         // Rounded-up reciprocal of the set count; exact for any partial value below 2^16.
         localparam logic [RECIP_W-1:0] RECIP =
            RECIP_W'(((1 << RECIP_SHIFT) + SET_COUNT - 1) / SET_COUNT);

         logic [PAD_W-1:0]  num_ff, num_in;
         logic [PAD_W-1:0]  quo_ff, quo_in;
         logic [SET_W-1:0]  rem_ff, rem_in;
         logic [CNT_W-1:0]  cnt_ff, cnt_in;
         logic              busy_ff, busy_in;
         logic              done_ff, done_in;
         logic [VAL_W-1:0]  part;
         logic [PROD_W-1:0] product;
         logic [7:0]        digit_q;
         logic [VAL_W-1:0]  digit_rem;

         // Long division one byte per cycle, most significant first. Each quotient byte
         // comes from a multiply by the reciprocal, and the remainder from a subtract.
         always_comb begin
            part = {rem_ff, num_ff[PAD_W-1 -: 8]};
            product = PROD_W'(part) * PROD_W'(RECIP);
            digit_q = product[RECIP_SHIFT +: 8];
            digit_rem = part - VAL_W'(digit_q) * VAL_W'(SET_COUNT);
            num_in = num_ff;
            quo_in = quo_ff;
            rem_in = rem_ff;
            cnt_in = cnt_ff;
            busy_in = busy_ff;
            done_in = 1'b0;
            if (start) begin
               num_in = PAD_W'(dividend);
               quo_in = '0;
               rem_in = '0;
               cnt_in = '0;
               busy_in = 1'b1;
            end else if (busy_ff) begin
               num_in = num_ff << 8;
               quo_in = {quo_ff[PAD_W-9:0], digit_q};
               rem_in = digit_rem[SET_W-1:0];
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DIGITS - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            num_ff <= num_in;
            quo_ff <= quo_in;
            rem_ff <= rem_in;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               cnt_ff <= '0;
               busy_ff <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_in;
               busy_ff <= busy_in;
               done_ff <= done_in;
            end
         end

         assign quotient = quo_ff[DIVIDEND_W-1:0];
         assign remainder = rem_ff;
         assign done = done_ff;
      end
   endgenerate

endmodule

### src/satlb_dp.sv
// Datapath: set/tag split, row memories, hit and victim logic, LRU update, result register.
module satlb_dp #(
   parameter int PAGE_OFFSET_BITS = satlb_pkg::DEFAULT_PAGE_OFFSET_BITS,
   parameter int SET_COUNT = satlb_pkg::DEFAULT_SET_COUNT,
   parameter int WAY_COUNT = satlb_pkg::DEFAULT_WAY_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  satlb_pkg::ctl_cmd_type cmd,
   output satlb_pkg::dp_sts_type  sts,
   input  satlb_pkg::req_type     req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output satlb_pkg::rsp_type     rsp_payload
);

   localparam int AW = satlb_pkg::ADDR_W;
   localparam int TW = satlb_pkg::TAG_W;
   localparam int FW = satlb_pkg::FRAME_W;
   localparam int ROW = satlb_pkg::RANK_OUT_W;
   localparam int VPN_W = AW - PAGE_OFFSET_BITS;
   localparam int SET_W = $clog2(SET_COUNT);
   localparam int WAY_IDX_W = $clog2(WAY_COUNT);
   localparam int RANK_W = $clog2(WAY_COUNT + 1);

   // Latched request.
   satlb_pkg::req_type req_ff;

   // Divider results.
   logic [VPN_W-1:0] div_quo;
   logic [SET_W-1:0] set_idx;
   logic             div_done;
   logic [TW-1:0]    tag_cur;

   // Row memories, one row per set holding all ways.
   logic [WAY_COUNT-1:0]              valid_mem [SET_COUNT];
   logic [WAY_COUNT-1:0][RANK_W-1:0]  rank_mem  [SET_COUNT];
   logic [WAY_COUNT-1:0][TW-1:0]      tag_mem   [SET_COUNT];
   logic [WAY_COUNT-1:0][FW-1:0]      frame_mem [SET_COUNT];

   // Registered row read.
   logic [WAY_COUNT-1:0]              valid_rd_ff;
   logic [WAY_COUNT-1:0][RANK_W-1:0]  rank_rd_ff;
   logic [WAY_COUNT-1:0][TW-1:0]      tag_rd_ff;
   logic [WAY_COUNT-1:0][FW-1:0]      frame_rd_ff;
   logic                              live_rd_ff;

   // A row whose flag is clear reads as empty; reset and clear drop all flags.
   logic [SET_COUNT-1:0] row_live_ff;

   // Lookup and update logic.
   logic [WAY_COUNT-1:0]              row_valid;
   logic [WAY_COUNT-1:0][RANK_W-1:0]  row_rank;
   logic [WAY_COUNT-1:0]              hit_vec;
   logic                              hit_any;
   logic [WAY_IDX_W-1:0]              hit_way;
   logic                              free_any;
   logic [WAY_IDX_W-1:0]              free_way;
   logic [WAY_IDX_W-1:0]              old_way;
   logic [WAY_IDX_W-1:0]              sel_way;
   logic [RANK_W-1:0]                 prev_rank;
   logic [WAY_COUNT-1:0]              new_valid;
   logic [WAY_COUNT-1:0][RANK_W-1:0]  new_rank;
   logic [WAY_COUNT-1:0][TW-1:0]      new_tag;
   logic [WAY_COUNT-1:0][FW-1:0]      new_frame;
   logic [FW-1:0]                     fill_frame;
   logic [PAGE_OFFSET_BITS-1:0]       offset;
   logic                              is_fill_ok;
   logic                              mem_wr;
   satlb_pkg::rsp_type                rsp_in;

   // Result register.
   satlb_pkg::rsp_type rsp_ff;
   logic               rsp_valid_ff;

   // Capture the request on its transfer.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_payload;
      end
   end

   // The divider starts on the transfer, straight from the port.
   satlb_div #(
      .DIVIDEND_W(VPN_W),
      .SET_COUNT (SET_COUNT)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.accept),
      .dividend (req_payload.virtual_address[AW-1:PAGE_OFFSET_BITS]),
      .quotient (div_quo),
      .remainder(set_idx),
      .done     (div_done)
   );

   assign tag_cur = TW'(div_quo);
   assign offset = req_ff.virtual_address[PAGE_OFFSET_BITS-1:0];
   assign fill_frame = FW'(req_ff.walk_frame_address >> PAGE_OFFSET_BITS);

   // Row read, registered.
   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         valid_rd_ff <= valid_mem[set_idx];
         rank_rd_ff <= rank_mem[set_idx];
         tag_rd_ff <= tag_mem[set_idx];
         frame_rd_ff <= frame_mem[set_idx];
         live_rd_ff <= row_live_ff[set_idx];
      end
   end

   // Row write-back.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         valid_mem[set_idx] <= new_valid;
         rank_mem[set_idx] <= new_rank;
         tag_mem[set_idx] <= new_tag;
         frame_mem[set_idx] <= new_frame;
      end
   end

   // Hit search and victim choice over the ways of the row.
   always_comb begin
      row_valid = live_rd_ff ? valid_rd_ff : '0;
      hit_vec = '0;
      hit_way = '0;
      free_any = 1'b0;
      free_way = '0;
      for (int w = WAY_COUNT - 1; w >= 0; w--) begin
         row_rank[w] = live_rd_ff ? rank_rd_ff[w] : '0;
         hit_vec[w] = row_valid[w] && (tag_rd_ff[w] == tag_cur);
         if (hit_vec[w]) begin
            hit_way = WAY_IDX_W'(w);
         end
         if (!row_valid[w]) begin
            free_any = 1'b1;
            free_way = WAY_IDX_W'(w);
         end
      end
      hit_any = |hit_vec;
      // Least recent way, lowest number on a tie.
      old_way = '0;
      for (int w = 1; w < WAY_COUNT; w++) begin
         if (row_rank[w] > row_rank[old_way]) begin
            old_way = WAY_IDX_W'(w);
         end
      end
      sel_way = hit_any ? hit_way : (free_any ? free_way : old_way);
      prev_rank = hit_any ? row_rank[hit_way] : '0;
   end

   // Recency update: the chosen way becomes most recent, more recent ways age.
   always_comb begin
      is_fill_ok = (req_ff.operation == satlb_pkg::OP_FILL) && !req_ff.walk_fault;
      new_valid = row_valid;
      new_tag = tag_rd_ff;
      new_frame = frame_rd_ff;
      for (int w = 0; w < WAY_COUNT; w++) begin
         if (WAY_IDX_W'(w) == sel_way) begin
            new_rank[w] = RANK_W'(1);
         end else if (row_valid[w] && ((prev_rank == '0) || (row_rank[w] < prev_rank))) begin
            new_rank[w] = row_rank[w] + 1'b1;
         end else begin
            new_rank[w] = row_rank[w];
         end
      end
      new_valid[sel_way] = 1'b1;
      if (is_fill_ok) begin
         new_tag[sel_way] = tag_cur;
         new_frame[sel_way] = fill_frame;
      end
      mem_wr = cmd.commit
               && (((req_ff.operation == satlb_pkg::OP_TRANSLATE) && hit_any) || is_fill_ok);
   end

   // Result of the operation.
   always_comb begin
      rsp_in = '0;
      case (req_ff.operation)
         satlb_pkg::OP_TRANSLATE: begin
            if (hit_any) begin
               rsp_in.status = satlb_pkg::RSP_HIT;
               rsp_in.physical_address = (AW'(frame_rd_ff[hit_way]) << PAGE_OFFSET_BITS)
                                         | AW'(offset);
            end else begin
               rsp_in.status = satlb_pkg::RSP_MISS;
            end
         end
         satlb_pkg::OP_FILL: begin
            if (req_ff.walk_fault) begin
               rsp_in.status = satlb_pkg::RSP_FAULT;
            end else begin
               rsp_in.status = satlb_pkg::RSP_INSTALLED;
               rsp_in.physical_address = (AW'(fill_frame) << PAGE_OFFSET_BITS) | AW'(offset);
            end
         end
         satlb_pkg::OP_PEEK: begin
            rsp_in.status = satlb_pkg::RSP_PEEK_DONE;
            if (hit_any) begin
               rsp_in.recency_rank = ROW'(row_rank[hit_way]);
            end
         end
         default: begin
            rsp_in.status = satlb_pkg::RSP_CLEARED;
         end
      endcase
   end

   // Row flags: set by an install, dropped by clear and reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_live_ff <= '0;
      end else if (cmd.commit && (req_ff.operation == satlb_pkg::OP_CLEAR)) begin
         row_live_ff <= '0;
      end else if (cmd.commit && is_fill_ok) begin
         row_live_ff[set_idx] <= 1'b1;
      end
   end

   // Result register, parting the lookup from the response side.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign sts.div_done = div_done;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   // A commit never overwrites a result that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   // After a clear no row may still read as live.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (req_ff.operation == satlb_pkg::OP_CLEAR)) |=> (row_live_ff == '0))
      else $error("row flags survived a clear");

   // A successful fill reports an install and leaves its row live.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && is_fill_ok) |=>
         (rsp_ff.status == satlb_pkg::RSP_INSTALLED) && rsp_valid_ff
         && row_live_ff[$past(set_idx)])
      else $error("fill did not install");

endmodule

### src/satlb_ctrl.sv
// Controller: sequences accept, divide, row read and update for one item at a time.
module satlb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  satlb_pkg::dp_sts_type  sts,
   output satlb_pkg::ctl_cmd_type cmd
);

   satlb_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= satlb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         satlb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = satlb_pkg::ST_DIVIDE;
            end
         end
         satlb_pkg::ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = satlb_pkg::ST_READ;
            end
         end
         satlb_pkg::ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in = satlb_pkg::ST_UPDATE;
         end
         satlb_pkg::ST_UPDATE: begin
            // Wait here until the result register can take the new result.
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in = satlb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = satlb_pkg::ST_IDLE;
         end
      endcase
   end

   // An update held back by a full result register stays pending.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == satlb_pkg::ST_UPDATE) && !sts.out_free) |=>
         (state_ff == satlb_pkg::ST_UPDATE))
      else $error("pending update dropped");

endmodule

### bench/satlb_tlb_checker.sv
// Checker for the set-associative TLB: predicts each result and compares it field by field.
`timescale 1ns / 100ps

module satlb_tlb_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  satlb_pkg::req_type req_payload,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  satlb_pkg::rsp_type rsp_payload,
   output int                 results_pending,
   output int                 mismatch_count
);

   localparam int OFFSET_BITS = satlb_pkg::DEFAULT_PAGE_OFFSET_BITS;
   localparam int SETS = satlb_pkg::DEFAULT_SET_COUNT;
   localparam int WAYS = satlb_pkg::DEFAULT_WAY_COUNT;
   localparam int ENTRIES = SETS * WAYS;
   localparam int REPORT_CAP = 200;
   localparam int ADDR_W = satlb_pkg::ADDR_W;
   localparam int TAG_W = satlb_pkg::TAG_W;
   localparam int FRAME_W = satlb_pkg::FRAME_W;
   localparam int RANK_OUT_W = satlb_pkg::RANK_OUT_W;

   // Shadow copy of the translation entries.
   logic              line_valid [ENTRIES];
   logic [TAG_W-1:0]  line_tag   [ENTRIES];
   logic [FRAME_W-1:0] line_frame [ENTRIES];
   logic [7:0]        line_rank  [ENTRIES];

   // Results still owed by the block, oldest first.
   satlb_pkg::rsp_type expected_results [$];
   satlb_pkg::rsp_type oldest_result;

   // Prints one mismatch line (up to a cap) and counts it.
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP) begin
         $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
   endtask

   // Returns the way of the set that holds the tag, or -1.
   function automatic int find_way(int base, logic [TAG_W-1:0] tag);
      for (int w = 0; w < WAYS; w++) begin
         if (line_valid[base + w] && line_tag[base + w] == tag) begin
            return w;
         end
      end
      return -1;
   endfunction

   // Makes a way the most recent; ways more recent than it age by one.
   // A way placed fresh carries rank 0, so every other valid way ages.
   function automatic void promote_way(int base, int way);
      logic [7:0] prior;
      prior = line_rank[base + way];
      for (int i = 0; i < WAYS; i++) begin
         if (i != way && line_valid[base + i] &&
             (prior == 0 || line_rank[base + i] < prior)) begin
            line_rank[base + i] = line_rank[base + i] + 8'd1;
         end
      end
      line_rank[base + way] = 8'd1;
   endfunction

   // Applies one operation to the shadow entries and returns its result.
   function automatic satlb_pkg::rsp_type lookup_result(satlb_pkg::req_type item);
      satlb_pkg::rsp_type result;
      logic [ADDR_W-1:0]  offset;
      logic [ADDR_W-1:0]  vpn;
      logic [TAG_W-1:0]   tag;
      logic [FRAME_W-1:0] frame;
      int                 base;
      int                 way;

      offset = item.virtual_address & ((64'd1 << OFFSET_BITS) - 64'd1);
      vpn = item.virtual_address >> OFFSET_BITS;
      base = int'(vpn % SETS) * WAYS;
      tag = TAG_W'(vpn / SETS);
      result = '0;

      case (item.operation)
         satlb_pkg::OP_TRANSLATE: begin
            way = find_way(base, tag);
            if (way >= 0) begin
               result.physical_address =
                  (ADDR_W'(line_frame[base + way]) << OFFSET_BITS) + offset;
               promote_way(base, way);
               result.status = satlb_pkg::RSP_HIT;
            end else begin
               result.status = satlb_pkg::RSP_MISS;
            end
         end
         satlb_pkg::OP_FILL: begin
            if (item.walk_fault) begin
               result.status = satlb_pkg::RSP_FAULT;
            end else begin
               frame = FRAME_W'(item.walk_frame_address >> OFFSET_BITS);
               way = find_way(base, tag);
               if (way < 0) begin
                  // Lowest invalid way first, else the least recent, lowest number on a tie.
                  for (int w = 0; w < WAYS; w++) begin
                     if (!line_valid[base + w] && way < 0) begin
                        way = w;
                     end
                  end
                  if (way < 0) begin
                     way = 0;
                     for (int w = 1; w < WAYS; w++) begin
                        if (line_rank[base + w] > line_rank[base + way]) begin
                           way = w;
                        end
                     end
                  end
                  line_rank[base + way] = 8'd0;
               end
               line_valid[base + way] = 1'b1;
               line_tag[base + way] = tag;
               line_frame[base + way] = frame;
               promote_way(base, way);
               result.physical_address = (ADDR_W'(frame) << OFFSET_BITS) + offset;
               result.status = satlb_pkg::RSP_INSTALLED;
            end
         end
         satlb_pkg::OP_PEEK: begin
            way = find_way(base, tag);
            if (way >= 0) begin
               result.recency_rank = RANK_OUT_W'(line_rank[base + way]);
            end
            result.status = satlb_pkg::RSP_PEEK_DONE;
         end
         default: begin
            for (int e = 0; e < ENTRIES; e++) begin
               line_valid[e] = 1'b0;
               line_rank[e] = 8'd0;
            end
            result.status = satlb_pkg::RSP_CLEARED;
         end
      endcase
      return result;
   endfunction

   // Watch both channels; a result is checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < ENTRIES; e++) begin
            line_valid[e] = 1'b0;
            line_rank[e] = 8'd0;
         end
         expected_results.delete();
         mismatch_count = 0;
         results_pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result status", 64'(rsp_payload.status), 64'd0);
            end else begin
               oldest_result = expected_results.pop_front();
               if (rsp_payload.status !== oldest_result.status) begin
                  report_mismatch("status", 64'(rsp_payload.status), 64'(oldest_result.status));
               end
               if (rsp_payload.physical_address !== oldest_result.physical_address) begin
                  report_mismatch("physical_address", rsp_payload.physical_address,
                                  oldest_result.physical_address);
               end
               if (rsp_payload.recency_rank !== oldest_result.recency_rank) begin
                  report_mismatch("recency_rank", 64'(rsp_payload.recency_rank),
                                  64'(oldest_result.recency_rank));
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(lookup_result(req_payload));
         end
         results_pending <= expected_results.size();
      end
   end

endmodule

### bench/set_associative_tlb_lru_core_tb.sv
// Testbench top for the set-associative TLB: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps

module set_associative_tlb_lru_core_tb;

   localparam int ADDR_W = satlb_pkg::ADDR_W;
   localparam int TAG_W = satlb_pkg::TAG_W;
   localparam int OFFSET_BITS = satlb_pkg::DEFAULT_PAGE_OFFSET_BITS;
   localparam int SETS = satlb_pkg::DEFAULT_SET_COUNT;
   localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
   localparam logic [ADDR_W-1:0] OFFSET_MASK = (64'd1 << OFFSET_BITS) - 64'd1;
   localparam int ITEM_TARGET = 1700;
   localparam int PAGE_POOL = 12;
   localparam int IDLE_PERCENT = 9;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int DRAIN_CYCLES = 20;
   localparam int WATCHDOG_LIMIT = 1000;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   satlb_pkg::req_type req_payload;
   logic               rsp_valid;
   logic               rsp_stall;
   satlb_pkg::rsp_type rsp_payload;

   int results_pending;
   int mismatch_count;
   int sent_count = 0;
   int quiet_cycles = 0;
   int receiver_cycles = 0;
   bit held_off = 1'b0;

   // Pool of pages that the random part revisits, spread over a few busy sets.
   logic [TAG_W-1:0] pool_tag [PAGE_POOL];
   int               pool_set [PAGE_POOL];
   int               busy_sets [3];
   int               pick;
   int               choice;
   logic [ADDR_W-1:0] page_va;

   always #6 clock = ~clock;

   set_associative_tlb_lru_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   satlb_tlb_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .results_pending (results_pending),
      .mismatch_count  (mismatch_count)
   );

   // Builds a virtual address from set index, tag and page offset.
   function automatic logic [ADDR_W-1:0] page_address(int set_index, logic [TAG_W-1:0] tag,
                                                      logic [ADDR_W-1:0] offset);
      return (((ADDR_W'(tag) * SETS) + ADDR_W'(set_index)) << OFFSET_BITS) |
             (offset & OFFSET_MASK);
   endfunction

   function automatic logic [ADDR_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Offers one request and holds it until the transfer; may idle first.
   task automatic issue_request(satlb_pkg::op_type op, logic [ADDR_W-1:0] va,
                                logic [ADDR_W-1:0] frame, logic fault);
      satlb_pkg::req_type item;
      item.operation = op;
      item.virtual_address = va;
      item.walk_frame_address = frame;
      item.walk_fault = fault;
      // No idling for a stretch in the middle of the run.
      if ((sent_count < 900 || sent_count > 1200) &&
          $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(5, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // Receiver: random stalls, one long hold-off to fill the block, and a stall-free stretch.
   initial begin
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held_off && sent_count >= 400) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= (receiver_cycles < 3000 || receiver_cycles > 5000) &&
                         ($urandom_range(99) < IDLE_PERCENT);
            @(posedge clock);
         end
         receiver_cycles++;
      end
   end

   // Watchdog: ends the run when nothing has transferred for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus and verdict.
   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty buffer, extreme addresses and a walker fault.
      issue_request(satlb_pkg::OP_CLEAR, '0, '0, 1'b0);
      issue_request(satlb_pkg::OP_TRANSLATE, '0, ADDR_ONES, 1'b1);
      issue_request(satlb_pkg::OP_PEEK, ADDR_ONES, '0, 1'b0);
      issue_request(satlb_pkg::OP_FILL, ADDR_ONES, ADDR_ONES, 1'b1);
      issue_request(satlb_pkg::OP_FILL, ADDR_ONES, ADDR_ONES, 1'b0);
      issue_request(satlb_pkg::OP_TRANSLATE, ADDR_ONES, '0, 1'b0);
      issue_request(satlb_pkg::OP_PEEK, ADDR_ONES, '0, 1'b0);

      // Fill all four ways of set 0, then refresh a middle-ranked way.
      for (int t = 0; t < 4; t++) begin
         issue_request(satlb_pkg::OP_FILL, page_address(0, TAG_W'(t), ADDR_W'(t)),
                       (t == 0) ? '0 : random_word(), 1'b0);
      end
      issue_request(satlb_pkg::OP_TRANSLATE, page_address(0, 1, 64'hABC), '0, 1'b0);
      issue_request(satlb_pkg::OP_PEEK, page_address(0, 0, 0), '0, 1'b0);

      // Eviction of the least recent way, then a refill of a present page in place.
      issue_request(satlb_pkg::OP_FILL, page_address(0, 4, 64'h123), random_word(), 1'b0);
      issue_request(satlb_pkg::OP_TRANSLATE, page_address(0, 0, 64'hFFF), '0, 1'b0);
      issue_request(satlb_pkg::OP_PEEK, page_address(0, 2, 0), '0, 1'b0);
      issue_request(satlb_pkg::OP_FILL, page_address(0, 2, 5), random_word(), 1'b0);
      issue_request(satlb_pkg::OP_TRANSLATE, page_address(0, 2, 64'h7), '0, 1'b0);
      issue_request(satlb_pkg::OP_PEEK, page_address(0, 3, 0), '0, 1'b0);

      // Clear, then use the emptied set again.
      issue_request(satlb_pkg::OP_CLEAR, ADDR_ONES, ADDR_ONES, 1'b1);
      issue_request(satlb_pkg::OP_TRANSLATE, page_address(0, 1, 0), '0, 1'b0);
      issue_request(satlb_pkg::OP_PEEK, page_address(0, 1, 0), '0, 1'b0);
      issue_request(satlb_pkg::OP_FILL, page_address(0, 1, 0), random_word(), 1'b0);

      // Random part: mostly walk sequences on pooled pages, some single operations and noise.
      busy_sets[0] = 0;
      busy_sets[1] = SETS - 1;
      busy_sets[2] = $urandom_range(SETS - 2, 1);
      for (int p = 0; p < PAGE_POOL; p++) begin
         pool_tag[p] = TAG_W'(random_word());
         pool_set[p] = busy_sets[$urandom_range(2)];
      end
      while (sent_count < ITEM_TARGET) begin
         pick = $urandom_range(PAGE_POOL - 1);
         if ($urandom_range(99) < 4) begin
            pool_tag[pick] = TAG_W'(random_word());
         end
         page_va = page_address(pool_set[pick], pool_tag[pick], random_word());
         choice = $urandom_range(99);
         if (choice < 55) begin
            // Translation, walk answer, then a second translation of the page, which hits unless the walk faulted.
            issue_request(satlb_pkg::OP_TRANSLATE, page_va, random_word(),
                          1'($urandom_range(1)));
            issue_request(satlb_pkg::OP_FILL, page_va, random_word(),
                          $urandom_range(99) < 12);
            issue_request(satlb_pkg::OP_TRANSLATE,
                          page_address(pool_set[pick], pool_tag[pick], random_word()),
                          random_word(), 1'b0);
            if ($urandom_range(1)) begin
               issue_request(satlb_pkg::OP_PEEK, page_va, random_word(),
                             1'($urandom_range(1)));
            end
         end else if (choice < 88) begin
            issue_request(satlb_pkg::op_type'($urandom_range(2)), page_va, random_word(),
                          $urandom_range(99) < 12);
         end else if (choice < 91) begin
            issue_request(satlb_pkg::OP_CLEAR, random_word(), random_word(),
                          1'($urandom_range(1)));
         end else begin
            issue_request(satlb_pkg::op_type'($urandom_range(3)), random_word(),
                          random_word(), 1'($urandom_range(1)));
         end
      end
      req_valid <= 1'b0;

      // Wait for every owed result, then let the block settle.
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
src/satlb_pkg.sv
src/satlb_div.sv
src/satlb_dp.sv
src/satlb_ctrl.sv
src/set_associative_tlb_lru_core.sv
bench/satlb_tlb_checker.sv
bench/set_associative_tlb_lru_core_tb.sv
